FILE: rtl/rgb_ycbcr_color_converter_macros.svh
// Assertion macros for the RGB/YCbCr color converter.
`ifndef RGB_YCBCR_COLOR_CONVERTER_MACROS_SVH
`define RGB_YCBCR_COLOR_CONVERTER_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent true implies consequent in the same cycle.
`define RYC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ryc assertion failed");
// Antecedent true implies consequent in the next cycle.
`define RYC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ryc assertion failed");
`else
`define RYC_ASSERT_SAME(label, clk, rst, ante, cons)
`define RYC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/ryc_pkg.sv
// Constants, types and coefficient tables for the RGB/YCbCr color converter.
package ryc_pkg;

   localparam int COEF_FRAC_BITS = 16;
   localparam int COMP_W         = 8;
   localparam int X_W            = COMP_W + 1;
   localparam int COEF_W         = COEF_FRAC_BITS + 2;
   localparam int PROD_W         = COEF_W + X_W;
   localparam int ACC_W          = PROD_W + 2;
   localparam int RND_W          = ACC_W - COEF_FRAC_BITS;
   localparam int OFS_W          = RND_W + 1;

   localparam logic DIR_FWD = 1'b0;
   localparam logic DIR_INV = 1'b1;

   typedef logic [COMP_W-1:0]        comp_type;
   typedef logic signed [X_W-1:0]    x_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [RND_W-1:0]  rnd_type;
   typedef logic signed [OFS_W-1:0]  ofs_type;

   localparam acc_type  ROUND_HALF = acc_type'(longint'(1) << (COEF_FRAC_BITS - 1));
   localparam x_type    CHROMA_BIAS = x_type'(128);
   localparam ofs_type  CHROMA_OFS  = ofs_type'(128);
   localparam ofs_type  COMP_MAX    = ofs_type'((1 << COMP_W) - 1);

   // Coefficient in units of 1/10000 to fixed point, half away from zero.
   function automatic coef_type fx_coef(input int tenk);
      longint mag;
      longint v;
      mag = (tenk < 0) ? -longint'(tenk) : longint'(tenk);
      v   = ((mag << COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000;
      return coef_type'((tenk < 0) ? -v : v);
   endfunction

   localparam coef_type FWD_COEF [3][3] = '{
      '{fx_coef(2990),  fx_coef(5870),  fx_coef(1140)},
      '{fx_coef(-1687), fx_coef(-3313), fx_coef(5000)},
      '{fx_coef(5000),  fx_coef(-4187), fx_coef(-813)}
   };

   localparam coef_type INV_COEF [3][3] = '{
      '{fx_coef(10000), fx_coef(0),     fx_coef(14020)},
      '{fx_coef(10000), fx_coef(-3441), fx_coef(-7141)},
      '{fx_coef(10000), fx_coef(17720), fx_coef(0)}
   };

endpackage

FILE: rtl/ryc_channels.sv
// Request and response channel interfaces of the color converter.
interface ryc_req_if;
   logic              valid;
   logic              ready;
   ryc_pkg::comp_type comp_a;
   ryc_pkg::comp_type comp_b;
   ryc_pkg::comp_type comp_c;
   modport source (output valid, output comp_a, output comp_b, output comp_c, input ready);
   modport sink (input valid, input comp_a, input comp_b, input comp_c, output ready);
endinterface

interface ryc_rsp_if;
   logic              valid;
   logic              ready;
   ryc_pkg::comp_type out_a;
   ryc_pkg::comp_type out_b;
   ryc_pkg::comp_type out_c;
   modport source (output valid, output out_a, output out_b, output out_c, input ready);
   modport sink (input valid, input out_a, input out_b, input out_c, output ready);
endinterface

FILE: rtl/rgb_ycbcr_color_converter.sv
// Full-range BT.601 RGB <-> YCbCr converter, four-stage pipeline.
// One pixel per request, one result per request, in order. The block takes a
// new request every clock cycle unless the response side stalls; each request
// passes the input register, nine coefficient products, row sums, then rounding
// with chroma offset and clamping into the output register, in order. A stall
// on the response side backs up stage by stage; empty stages keep filling, so
// up to four requests sit inside while the output waits. csr_wr_data picks the
// direction (0 RGB to YCbCr, 1 YCbCr to RGB); write it only while the pipeline
// is empty. Each request carries the direction it entered with.
`include "rgb_ycbcr_color_converter_macros.svh"

module rgb_ycbcr_color_converter (
   input  logic  clock,
   input  logic  reset,
   input  logic  csr_wr_en,
   input  logic  csr_wr_data,
   ryc_req_if.sink   req,
   ryc_rsp_if.source rsp
);

   logic direction_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;

   logic dir1_ff, dir2_ff, dir3_ff;
   ryc_pkg::x_type    x_ff   [3];
   ryc_pkg::x_type    x_in   [3];
   ryc_pkg::prod_type prod_ff [3][3];
   ryc_pkg::prod_type prod_in [3][3];
   ryc_pkg::acc_type  acc_ff [3];
   ryc_pkg::acc_type  acc_in [3];
   ryc_pkg::comp_type res_ff [3];
   ryc_pkg::comp_type res_in [3];

   // stall chain: a stage moves when it is empty or the next one moves
   assign en4 = !v4_ff || rsp.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req.ready = en1;
   assign v1_in = en1 ? req.valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= ryc_pkg::DIR_FWD;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            direction_ff <= csr_wr_data;
         end
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage 1: operands, chroma bias removed on the inverse path
   always_comb begin
      x_in[0] = ryc_pkg::x_type'({1'b0, req.comp_a});
      x_in[1] = ryc_pkg::x_type'({1'b0, req.comp_b});
      x_in[2] = ryc_pkg::x_type'({1'b0, req.comp_c});
      if (direction_ff == ryc_pkg::DIR_INV) begin
         x_in[1] = x_in[1] - ryc_pkg::CHROMA_BIAS;
         x_in[2] = x_in[2] - ryc_pkg::CHROMA_BIAS;
      end
   end

   // stage 2: nine products
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = ryc_pkg::prod_type'(
                               (dir1_ff == ryc_pkg::DIR_INV) ? ryc_pkg::INV_COEF[r][k]
                                                             : ryc_pkg::FWD_COEF[r][k])
                          * ryc_pkg::prod_type'(x_ff[k]);
         end
      end
   end

   // stage 3: row sums
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = ryc_pkg::acc_type'(prod_ff[r][0]) + ryc_pkg::acc_type'(prod_ff[r][1])
                   + ryc_pkg::acc_type'(prod_ff[r][2]);
      end
   end

   // stage 4: round half away from zero, chroma offset, clamp
   always_comb begin
      ryc_pkg::acc_type t;
      ryc_pkg::ofs_type v;
      for (int r = 0; r < 3; r++) begin
         // floor((a + half - neg) / 2^F) matches rounding away from zero
         t = acc_ff[r] + ryc_pkg::ROUND_HALF - ryc_pkg::acc_type'(acc_ff[r][ryc_pkg::ACC_W-1]);
         v = ryc_pkg::ofs_type'(ryc_pkg::rnd_type'(t[ryc_pkg::ACC_W-1:ryc_pkg::COEF_FRAC_BITS]));
         if (dir3_ff == ryc_pkg::DIR_FWD && r != 0) begin
            v = v + ryc_pkg::CHROMA_OFS;
         end
         if (v[ryc_pkg::OFS_W-1]) begin
            res_in[r] = '0;
         end else if (v > ryc_pkg::COMP_MAX) begin
            res_in[r] = '1;
         end else begin
            res_in[r] = v[ryc_pkg::COMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         dir1_ff <= direction_ff;
         x_ff    <= x_in;
      end
      if (en2) begin
         dir2_ff <= dir1_ff;
         prod_ff <= prod_in;
      end
      if (en3) begin
         dir3_ff <= dir2_ff;
         acc_ff  <= acc_in;
      end
      if (en4) begin
         res_ff  <= res_in;
      end
   end

   assign rsp.valid = v4_ff;
   assign rsp.out_a = res_ff[0];
   assign rsp.out_b = res_ff[1];
   assign rsp.out_c = res_ff[2];

   // dir2_ff only travels toward stage 3
   `RYC_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req.valid && req.ready, v1_ff)
   `RYC_ASSERT_SAME(a_empty_out_accepts, clock, reset, !rsp.valid, req.ready)
   `RYC_ASSERT_NEXT(a_s3_reaches_out, clock, reset, v3_ff && en4, rsp.valid)
   `RYC_ASSERT_NEXT(a_s3_holds, clock, reset, v3_ff && !en3,
                    v3_ff && $stable(acc_ff[0]) && $stable(acc_ff[1]) && $stable(acc_ff[2]))

endmodule

FILE: tb/tb_rgb_ycbcr_color_converter.sv
// Self-checking testbench for the RGB/YCbCr color converter.
module tb_rgb_ycbcr_color_converter;

   localparam int FRAC = ryc_pkg::COEF_FRAC_BITS;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 120;
   localparam int SEGMENT_ITEMS = 118;
   localparam longint TIMEOUT_CYCLES = 200000;

   typedef struct packed {
      ryc_pkg::comp_type a;
      ryc_pkg::comp_type b;
      ryc_pkg::comp_type c;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   ryc_req_if req_ch ();
   ryc_rsp_if rsp_ch ();

   rgb_ycbcr_color_converter dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   // Matrix coefficients in units of 1/10000.
   int fwd_tenk [3][3] = '{'{2990, 5870, 1140}, '{-1687, -3313, 5000}, '{5000, -4187, -813}};
   int inv_tenk [3][3] = '{'{10000, 0, 14020}, '{10000, -3441, -7141}, '{10000, 17720, 0}};

   pixel_type pending_pixels [$];
   pixel_type expected_pixels [$];
   logic model_dir = ryc_pkg::DIR_FWD;
   int send_idle_pct = 32;
   int recv_idle_pct = 66;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatch_count = 0;

   function automatic longint to_fixed(int tenk);
      longint mag;
      longint v;
      mag = (tenk < 0) ? -longint'(tenk) : longint'(tenk);
      v = (mag * (longint'(1) << FRAC) + 5000) / 10000;
      return (tenk < 0) ? -v : v;
   endfunction

   // Round half away from zero, add offset, clamp to a byte.
   function automatic ryc_pkg::comp_type round_clamp(longint acc, longint bias);
      longint half;
      longint r;
      half = longint'(1) << (FRAC - 1);
      if (acc >= 0) r = (acc + half) >>> FRAC;
      else r = -((half - acc) >>> FRAC);
      r = r + bias;
      if (r < 0) return ryc_pkg::comp_type'(0);
      if (r > 255) return ryc_pkg::comp_type'(255);
      return ryc_pkg::comp_type'(r);
   endfunction

   function automatic pixel_type convert_pixel(logic dir, pixel_type px);
      longint x [3];
      longint acc;
      longint bias;
      int tenk;
      ryc_pkg::comp_type res [3];
      pixel_type y;
      x[0] = px.a;
      x[1] = px.b;
      x[2] = px.c;
      if (dir == ryc_pkg::DIR_INV) begin
         x[1] = x[1] - 128;
         x[2] = x[2] - 128;
      end
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int k = 0; k < 3; k++) begin
            tenk = (dir == ryc_pkg::DIR_INV) ? inv_tenk[r][k] : fwd_tenk[r][k];
            acc = acc + to_fixed(tenk) * x[k];
         end
         bias = (dir == ryc_pkg::DIR_FWD && r != 0) ? 128 : 0;
         res[r] = round_clamp(acc, bias);
      end
      y.a = res[0];
      y.b = res[1];
      y.c = res[2];
      return y;
   endfunction

   task automatic report_field(string name, ryc_pkg::comp_type want, ryc_pkg::comp_type got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.comp_a = '0;
      req_ch.comp_b = '0;
      req_ch.comp_c = '0;
      rsp_ch.ready = 1'b0;
      forever #10 clock = ~clock;
   end

   // Request driver
   always @(posedge clock) begin
      pixel_type px;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            px = pending_pixels.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.comp_a <= px.a;
            req_ch.comp_b <= px.b;
            req_ch.comp_c <= px.c;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response sink, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on request accept, check on response accept
   always @(posedge clock) begin
      pixel_type want;
      pixel_type got;
      if (reset) begin
         model_dir <= ryc_pkg::DIR_FWD;
      end else begin
         if (csr_wr_en) model_dir <= csr_wr_data;
         if (req_ch.valid && req_ch.ready)
            expected_pixels.push_back(convert_pixel(model_dir,
               {req_ch.comp_a, req_ch.comp_b, req_ch.comp_c}));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.out_a, rsp_ch.out_b, rsp_ch.out_c};
            if (expected_pixels.size() == 0) begin
               $error("unexpected response %0d/%0d/%0d", got.a, got.b, got.c);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               report_field("out_a", want.a, got.a);
               report_field("out_b", want.b, got.b);
               report_field("out_c", want.c, got.c);
            end
         end
      end
   end

   // sampled mid-cycle so the driver and monitor updates of the edge are settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_ch.valid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_direction(logic dir);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= dir;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_pixel(int a, int b, int c);
      pending_pixels.push_back({ryc_pkg::comp_type'(a), ryc_pkg::comp_type'(b),
                                ryc_pkg::comp_type'(c)});
   endtask

   // Mostly uniform, with extra weight on the byte extremes.
   function automatic int rand_comp();
      case ($urandom_range(9))
         0: return 0;
         1: return 255;
         default: return $urandom_range(255);
      endcase
   endfunction

   task automatic push_random(int count);
      for (int i = 0; i < count; i++) push_pixel(rand_comp(), rand_comp(), rand_comp());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_direction(ryc_pkg::DIR_FWD);
      push_pixel(0, 0, 0);
      push_pixel(255, 255, 255);
      push_pixel(255, 0, 0);
      push_pixel(0, 255, 0);
      push_pixel(0, 0, 255);
      push_pixel(0, 255, 255);
      push_pixel(170, 85, 170);
      push_pixel(85, 170, 85);

      set_direction(ryc_pkg::DIR_INV);
      push_pixel(0, 128, 128);
      push_pixel(255, 128, 128);
      push_pixel(0, 0, 0);
      push_pixel(255, 255, 255);
      push_pixel(0, 255, 0);
      push_pixel(255, 0, 255);
      push_pixel(128, 0, 255);
      push_pixel(128, 255, 0);
      push_pixel(0, 0, 255);
      push_pixel(255, 255, 0);
      push_pixel(170, 85, 170);
      push_pixel(85, 170, 85);

      for (int phase = 0; phase < 3; phase++) begin
         for (int seg = 0; seg < 4; seg++) begin
            set_direction((seg % 2 == 0) ? ryc_pkg::DIR_FWD : ryc_pkg::DIR_INV);
            case (phase)
               0: begin send_idle_pct = 32; recv_idle_pct = 66; end
               1: begin send_idle_pct = 66; recv_idle_pct = 32; end
               default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            push_random(SEGMENT_ITEMS);
            // stall the response side while requests keep coming
            if (phase == 2 && seg == 0) hold_trigger++;
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("rgb_ycbcr_color_converter regression: pass");
      end else begin
         $display("rgb_ycbcr_color_converter regression: fail");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 20);
      $display("rgb_ycbcr_color_converter regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ryc_pkg.sv
rtl/ryc_channels.sv
rtl/rgb_ycbcr_color_converter.sv
tb/tb_rgb_ycbcr_color_converter.sv
